/* rtl/assert_macros.svh */
// Assertion helpers for the top-level RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked at every rising edge outside reset.
`define GR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define GR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

/* rtl/grgcs_pkg.sv */
package grgcs_pkg;

  localparam int GRID_COLS_DEF  = 64;
  localparam int GRID_ROWS_DEF  = 64;
  localparam int MAX_RADIUS_DEF = 8;

  localparam int CFG_IDX_W = 3;
  localparam int OFF_W     = 6;
  localparam int RAD_W     = 5;

  localparam logic [1:0] CMD_PLAN    = 2'd0;
  localparam logic [1:0] CMD_VISIT   = 2'd1;
  localparam logic [1:0] CMD_UNREACH = 2'd2;

  localparam logic [1:0] MARK_FREE    = 2'd0;
  localparam logic [1:0] MARK_VISITED = 2'd1;
  localparam logic [1:0] MARK_UNREACH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER    = 3'd6;

  localparam logic [30:0] CELL_RESET  = 31'd65536;
  localparam logic [6:0]  USED_RESET  = 7'd64;
  localparam logic [3:0]  INNER_RESET = 4'd1;
  localparam logic [3:0]  OUTER_RESET = 4'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_QX, ST_QXW, ST_QY, ST_QYW, ST_CX, ST_CY,
    ST_MARK, ST_CELL, ST_MEM, ST_ABS, ST_SQX, ST_SQY, ST_CMP, ST_RES
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic q_start;
    logic q_axis;
    logic ctr_x;
    logic ctr_y;
    logic mark_wr;
    logic step;
    logic abs_ld;
    logic sq_x;
    logic sq_y;
    logic cmp;
    logic res_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic q_done;
    logic in_bad;
    logic is_mark;
    logic skip;
    logic free;
    logic last;
    logic out_busy;
  } dp_stat_t;

endpackage

/* rtl/grgcs_quant.sv */
module grgcs_quant #(
  parameter int QB   = 6,
  parameter int CNTW = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] value,
  input  logic signed [31:0] org,
  input  logic [30:0]        cs,
  input  logic [CNTW-1:0]    count,
  output logic               done,
  output logic [QB-1:0]      res
);
  localparam int RW = 36 + QB;
  localparam int DW = 32 + QB;
  localparam int KW = $clog2(QB + 1);

  logic signed [34:0] diff, dval;
  logic [31:0]        dd;
  logic               dpos, ovf;
  logic               run, fin, zero, sat;
  logic [34:0]        rem;
  logic [DW-1:0]      dsh;
  logic [QB-1:0]      q;
  logic [KW-1:0]      k;
  logic [QB:0]        qinc;
  logic [CNTW-1:0]    lim;

  // Doubled distance from the first center, so the tie test stays exact.
  assign diff = 35'(value) - 35'(org);
  assign dval = (diff <<< 1) - $signed({4'b0, cs});
  assign dd   = {cs, 1'b0};
  assign dpos = !dval[34] && (dval != '0);
  assign ovf  = RW'($unsigned(dval)) >= RW'({dd, {QB{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        if (!dpos || ovf) begin
          fin <= 1'b1;
        end else begin
          run <= 1'b1;
        end
      end else if (run && k == KW'(1)) begin
        run <= 1'b0;
        fin <= 1'b1;
      end
    end
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      zero <= !dpos;
      sat  <= dpos && ovf;
      rem  <= $unsigned(dval);
      dsh  <= {dd, {QB{1'b0}}} >> 1;
      q    <= '0;
      k    <= KW'(QB);
    end else if (run) begin
      if (RW'(rem) >= RW'(dsh)) begin
        rem <= rem - 35'(dsh);
        q   <= (q << 1) | QB'(1);
      end else begin
        q   <= q << 1;
      end
      dsh <= dsh >> 1;
      k   <= k - KW'(1);
    end
  end

  assign qinc = (QB+1)'(q) + (QB+1)'(rem > {4'b0, cs});
  assign lim  = count - CNTW'(1);
  assign done = fin;

  always_comb begin
    if (zero) begin
      res = '0;
    end else if (sat || 32'(qinc) > 32'(lim)) begin
      res = QB'(lim);
    end else begin
      res = QB'(qinc);
    end
  end
endmodule

/* rtl/grgcs_ctrl.sv */
module grgcs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  grgcs_pkg::dp_stat_t stat,
  output grgcs_pkg::dp_cmd_t  cmd
);
  import grgcs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (stat.clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) state_next = stat.in_bad ? ST_RES : ST_QX;
      end
      ST_QX:  state_next = ST_QXW;
      ST_QXW: if (stat.q_done) state_next = ST_QY;
      ST_QY:  state_next = ST_QYW;
      ST_QYW: if (stat.q_done) state_next = ST_CX;
      ST_CX:  state_next = ST_CY;
      ST_CY:  state_next = stat.is_mark ? ST_MARK : ST_CELL;
      ST_MARK: state_next = ST_RES;
      ST_CELL: begin
        if (stat.skip) state_next = stat.last ? ST_RES : ST_CELL;
        else state_next = ST_MEM;
      end
      ST_MEM: begin
        if (!stat.free) state_next = stat.last ? ST_RES : ST_CELL;
        else state_next = ST_ABS;
      end
      ST_ABS: state_next = ST_SQX;
      ST_SQX: state_next = ST_SQY;
      ST_SQY: state_next = ST_CMP;
      ST_CMP: state_next = stat.last ? ST_RES : ST_CELL;
      ST_RES: if (!stat.out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state != ST_IDLE);
    cmd         = '0;
    cmd.clr     = (state == ST_CLEAR);
    cmd.load    = (state == ST_IDLE) && in_valid;
    cmd.q_start = (state == ST_QX) || (state == ST_QY);
    cmd.q_axis  = (state == ST_QY) || (state == ST_QYW);
    cmd.ctr_x   = (state == ST_CX);
    cmd.ctr_y   = (state == ST_CY);
    cmd.mark_wr = (state == ST_MARK);
    cmd.step    = ((state == ST_CELL) && stat.skip) ||
                  ((state == ST_MEM) && !stat.free) || (state == ST_CMP);
    cmd.abs_ld  = (state == ST_ABS);
    cmd.sq_x    = (state == ST_SQX);
    cmd.sq_y    = (state == ST_SQY);
    cmd.cmp     = (state == ST_CMP);
    cmd.res_ld  = (state == ST_RES) && !stat.out_busy;
  end
endmodule

/* rtl/grgcs_dp.sv */
module grgcs_dp #(
  parameter int GRID_COLS  = 64,
  parameter int GRID_ROWS  = 64,
  parameter int MAX_RADIUS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  grgcs_pkg::dp_cmd_t                 cmd,
  output grgcs_pkg::dp_stat_t                stat,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [grgcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                        cfg_data,
  input  logic [1:0]                         command,
  input  logic signed [31:0]                 pos_x,
  input  logic signed [31:0]                 pos_y,
  input  logic signed [31:0]                 goal_x,
  input  logic signed [31:0]                 goal_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               found,
  output logic [5:0]                         target_col,
  output logic [5:0]                         target_row,
  output logic signed [31:0]                 target_x,
  output logic signed [31:0]                 target_y
);
  import grgcs_pkg::*;

  localparam int GRID_MAX = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
  localparam int QB    = $clog2(GRID_MAX);
  localparam int CNTW  = $clog2(GRID_MAX + 1);
  localparam int SIW   = $clog2(GRID_MAX + 16) + 1;
  localparam int CTR_W = SIW + 34;
  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [CTR_W-1:0] SMAX = CTR_W'(2147483647);
  localparam logic signed [CTR_W-1:0] SMIN = ~SMAX;

  function automatic logic signed [31:0] sat32(input logic signed [CTR_W-1:0] v);
    if (v > SMAX) sat32 = 32'sh7FFF_FFFF;
    else if (v < SMIN) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

  // Configuration registers.
  logic signed [31:0] origin_x, origin_y;
  logic [30:0]        cell_size;
  logic [6:0]         used_cols, used_rows;
  logic [3:0]         inner_radius, outer_radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      cell_size    <= CELL_RESET;
      used_cols    <= USED_RESET;
      used_rows    <= USED_RESET;
      inner_radius <= INNER_RESET;
      outer_radius <= OUTER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ORIGIN_X: origin_x     <= cfg_data;
        CFG_ORIGIN_Y: origin_y     <= cfg_data;
        CFG_CELL:     cell_size    <= cfg_data[30:0];
        CFG_COLS:     used_cols    <= cfg_data[6:0];
        CFG_ROWS:     used_rows    <= cfg_data[6:0];
        CFG_INNER:    inner_radius <= cfg_data[3:0];
        CFG_OUTER:    outer_radius <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic [30:0]      cs_eff;
  logic [CNTW-1:0]  cols_eff, rows_eff;
  logic [RAD_W-1:0] rad;

  assign cs_eff = (cell_size == '0) ? 31'd1 : cell_size;
  assign rad    = (32'(outer_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                   : RAD_W'(outer_radius);

  always_comb begin
    if (used_cols == '0) cols_eff = CNTW'(1);
    else if (32'(used_cols) > GRID_COLS) cols_eff = CNTW'(GRID_COLS);
    else cols_eff = CNTW'(used_cols);
    if (used_rows == '0) rows_eff = CNTW'(1);
    else if (32'(used_rows) > GRID_ROWS) rows_eff = CNTW'(GRID_ROWS);
    else rows_eff = CNTW'(used_rows);
  end

  // Request capture.
  logic [1:0]         cmd_r;
  logic signed [31:0] px, py, gx, gy;
  logic               is_plan, is_mark;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= command;
      px    <= pos_x;
      py    <= pos_y;
      gx    <= goal_x;
      gy    <= goal_y;
    end
  end

  assign is_plan = (cmd_r == CMD_PLAN);
  assign is_mark = (cmd_r == CMD_VISIT) || (cmd_r == CMD_UNREACH);

  // Shared quantizer.
  logic          q_done;
  logic [QB-1:0] q_res;
  logic [QB-1:0] xc, yc;

  grgcs_quant #(.QB(QB), .CNTW(CNTW)) u_quant (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.q_start),
    .value (cmd.q_axis ? py : px),
    .org   (cmd.q_axis ? origin_y : origin_x),
    .cs    (cs_eff),
    .count (cmd.q_axis ? rows_eff : cols_eff),
    .done  (q_done),
    .res   (q_res)
  );

  always_ff @(posedge clk) begin
    if (q_done) begin
      if (cmd.q_axis) yc <= q_res;
      else xc <= q_res;
    end
  end

  // Center of the first cell (ring corner for a plan); later ones step by one cell size.
  logic [QB-1:0]            ctr_base;
  logic signed [SIW-1:0]    ctr_idx;
  logic signed [SIW+31:0]   ctr_prod;
  logic signed [31:0]       ctr_org;
  logic signed [CTR_W-1:0]  ctr_exact, cs_step;

  assign ctr_base  = cmd.ctr_y ? yc : xc;
  assign ctr_org   = cmd.ctr_y ? origin_y : origin_x;
  assign ctr_idx   = $signed(SIW'(ctr_base)) -
                     (is_plan ? $signed(SIW'(rad)) : $signed(SIW'(0)));
  assign ctr_prod  = $signed({1'b0, cs_eff}) * ctr_idx;
  assign ctr_exact = CTR_W'(ctr_org) + CTR_W'($signed({2'b0, cs_eff[30:1]})) +
                     CTR_W'(ctr_prod);
  assign cs_step   = CTR_W'($signed({1'b0, cs_eff}));

  logic signed [CTR_W-1:0] cx_cur, cy_cur, cy_start;
  logic signed [OFF_W-1:0] di, dj;
  logic signed [31:0]      cx_sat, cy_sat;

  assign cx_sat = sat32(cx_cur);
  assign cy_sat = sat32(cy_cur);

  always_ff @(posedge clk) begin
    if (cmd.ctr_x) begin
      cx_cur <= ctr_exact;
      di     <= -$signed(OFF_W'(rad));
      dj     <= -$signed(OFF_W'(rad));
    end else if (cmd.ctr_y) begin
      cy_cur   <= ctr_exact;
      cy_start <= ctr_exact;
    end else if (cmd.step) begin
      if (dj == $signed(OFF_W'(rad))) begin
        dj     <= -$signed(OFF_W'(rad));
        di     <= di + OFF_W'(1);
        cy_cur <= cy_start;
        cx_cur <= cx_cur + cs_step;
      end else begin
        dj     <= dj + OFF_W'(1);
        cy_cur <= cy_cur + cs_step;
      end
    end
  end

  // Current ring cell and its skip tests.
  logic signed [SIW-1:0] cc, rr;
  logic [OFF_W-1:0]      adi, adj;
  logic                  oob, inner_hit;
  logic [AW-1:0]         ring_addr, mark_addr, clr_addr, waddr;
  logic [1:0]            rdata, wdata;
  logic                  we;

  assign cc  = $signed(SIW'(xc)) + SIW'(di);
  assign rr  = $signed(SIW'(yc)) + SIW'(dj);
  assign adi = di[OFF_W-1] ? OFF_W'(-di) : OFF_W'(di);
  assign adj = dj[OFF_W-1] ? OFF_W'(-dj) : OFF_W'(dj);
  assign inner_hit = (adi < OFF_W'(inner_radius)) && (adj < OFF_W'(inner_radius));
  assign oob = (cc < $signed(SIW'(0))) || (cc >= $signed(SIW'(cols_eff))) ||
               (rr < $signed(SIW'(0))) || (rr >= $signed(SIW'(rows_eff)));

  assign ring_addr = AW'(AW'($unsigned(rr)) * AW'(GRID_COLS) + AW'($unsigned(cc)));
  assign mark_addr = AW'(AW'(yc) * AW'(GRID_COLS) + AW'(xc));

  // Cell mark memory, cleared by a sweep after reset.
  logic [1:0] marks [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign we    = cmd.clr || cmd.mark_wr;
  assign waddr = cmd.clr ? clr_addr : mark_addr;
  assign wdata = cmd.clr ? MARK_FREE :
                 (cmd_r == CMD_VISIT) ? MARK_VISITED : MARK_UNREACH;

  always_ff @(posedge clk) begin
    if (we) marks[waddr] <= wdata;
    rdata <= marks[ring_addr];
  end

  // Squared distance: one 32x32 multiplier used twice per cell.
  logic signed [32:0] dx, dy;
  logic [31:0]        ux, uy, mop;
  logic [63:0]        prod, sqx, sqy, dsq;
  logic [64:0]        sum;

  assign dx   = 33'(cx_sat) - 33'(gx);
  assign dy   = 33'(cy_sat) - 33'(gy);
  assign mop  = cmd.sq_y ? uy : ux;
  assign prod = mop * mop;
  assign sum  = {1'b0, sqx} + {1'b0, sqy};
  assign dsq  = sum[64] ? '1 : sum[63:0];

  always_ff @(posedge clk) begin
    if (cmd.abs_ld) begin
      ux <= dx[32] ? 32'(-dx) : dx[31:0];
      uy <= dy[32] ? 32'(-dy) : dy[31:0];
    end
    if (cmd.sq_x) sqx <= prod;
    if (cmd.sq_y) sqy <= prod;
  end

  // Best candidate so far; the first of equal distances is kept.
  logic               have;
  logic [63:0]        best;
  logic [QB-1:0]      bc, br;
  logic signed [31:0] bx, by;

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.ctr_x) begin
      have <= 1'b0;
    end else if (cmd.cmp && (!have || dsq < best)) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp && (!have || dsq < best)) begin
      best <= dsq;
      bc   <= QB'($unsigned(cc));
      br   <= QB'($unsigned(rr));
      bx   <= cx_sat;
      by   <= cy_sat;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      if (is_plan && have) begin
        found      <= 1'b1;
        target_col <= 6'(bc);
        target_row <= 6'(br);
        target_x   <= bx;
        target_y   <= by;
      end else if (is_mark) begin
        found      <= 1'b0;
        target_col <= 6'(xc);
        target_row <= 6'(yc);
        target_x   <= cx_sat;
        target_y   <= cy_sat;
      end else begin
        found      <= 1'b0;
        target_col <= '0;
        target_row <= '0;
        target_x   <= '0;
        target_y   <= '0;
      end
    end
  end

  always_comb begin
    stat          = '0;
    stat.clr_last = (clr_addr == AW'(DEPTH - 1));
    stat.q_done   = q_done;
    stat.in_bad   = (command != CMD_PLAN) && (command != CMD_VISIT) &&
                    (command != CMD_UNREACH);
    stat.is_mark  = is_mark;
    stat.skip     = inner_hit || oob;
    stat.free     = (rdata == MARK_FREE);
    stat.last     = (di == $signed(OFF_W'(rad))) && (dj == $signed(OFF_W'(rad)));
    stat.out_busy = out_valid && out_stall;
  end
endmodule

/* rtl/grid_ring_goal_cell_select_top.sv */
// A valid request has x and then y quantized and its cell centers formed; a mark then
// writes its cell, while a plan visits the (2R+1)^2 ring square, passing over skipped
// cells, dropping marked cells after the memory read, and ranking free cells by distance.
// One request is in flight at a time; the next is taken while the result waits.
// Reset: synchronous, active high; afterwards the mark memory is swept to free,
// one entry per cycle, before the first request is taken.
`include "assert_macros.svh"

module grid_ring_goal_cell_select_top #(
  parameter int GRID_COLS  = grgcs_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS  = grgcs_pkg::GRID_ROWS_DEF,
  parameter int MAX_RADIUS = grgcs_pkg::MAX_RADIUS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [grgcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      command,
  input  logic signed [31:0]              pos_x,
  input  logic signed [31:0]              pos_y,
  input  logic signed [31:0]              goal_x,
  input  logic signed [31:0]              goal_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [5:0]                      target_col,
  output logic [5:0]                      target_row,
  output logic signed [31:0]              target_x,
  output logic signed [31:0]              target_y
);
  import grgcs_pkg::*;

  // The controller sequences each request; the datapath holds configuration,
  // the quantizer, the ring counters, the mark memory and the distance unit.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  grgcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // A plan request walks columns outer and rows inner, so the first of
  // equally near free cells is the one reported.
  grgcs_dp #(
    .GRID_COLS  (GRID_COLS),
    .GRID_ROWS  (GRID_ROWS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .command    (command),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .goal_x     (goal_x),
    .goal_y     (goal_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .target_col (target_col),
    .target_row (target_row),
    .target_x   (target_x),
    .target_y   (target_y)
  );

  // An accepted request keeps the input side busy in the next cycle.
  `GR_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // A new result is never loaded over one that is still stalled.
  `GR_ASSERT_IMP(a_no_overwrite, cmd.res_ld, !(out_valid && out_stall))
  // No request is taken while the mark memory is being swept.
  `GR_ASSERT_IMP(a_clear_stalls, cmd.clr, in_stall)
  // A loaded result is presented in the next cycle.
  `GR_ASSERT_NXT(a_result_shown, cmd.res_ld, out_valid)
endmodule

/* verif/grid_ring_goal_cell_select_top_test.sv */
`timescale 1ns / 100ps

module grid_ring_goal_cell_select_top_test;
  import grgcs_pkg::*;

  // Command code 3 has no meaning in the block; it must answer with an all-zero result.
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  // Index 7 addresses no register and must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 165;
  // The slowest correct request is a plan at radius 8; with stalls and gaps on both sides,
  // about 2000 requests and the reset sweep still fit several times over in this bound.
  localparam longint CYCLE_LIMIT = 16000000;

  typedef struct packed {
    logic        found;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [31:0] x;
    logic [31:0] y;
  } cell_result_t;

  // The scoreboard keeps its own copy of the grid marks and registers, and predicts the
  // result of every accepted request in arrival order.
  class goal_cell_board;
    longint org_x, org_y, csize;
    int unsigned ucols, urows, inner, outer;
    bit [1:0] marks[GRID_COLS_DEF*GRID_ROWS_DEF];
    cell_result_t awaited_q[$];
    int errors;

    function new();
      org_x = 0;
      org_y = 0;
      csize = CELL_RESET;
      ucols = USED_RESET;
      urows = USED_RESET;
      inner = INNER_RESET;
      outer = OUTER_RESET;
      foreach (marks[i]) marks[i] = MARK_FREE;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        CFG_ORIGIN_X: org_x = $signed(v);
        CFG_ORIGIN_Y: org_y = $signed(v);
        CFG_CELL:     csize = v[30:0];
        CFG_COLS:     ucols = v[6:0];
        CFG_ROWS:     urows = v[6:0];
        CFG_INNER:    inner = v[3:0];
        CFG_OUTER:    outer = v[3:0];
        default: ;
      endcase
    endfunction

    function longint eff_cell();
      return (csize > 0) ? csize : 1;
    endfunction

    function longint eff_count(int unsigned r, longint lim);
      if (r == 0) return 1;
      if (r > lim) return lim;
      return r;
    endfunction

    // Nearest cell center, ties to the lower index, clamped to the used grid.
    function longint cell_index(longint v, longint org, longint count);
      longint cs, d, q, r;
      cs = eff_cell();
      d = 2 * (v - org) - cs;
      if (d <= 0) return 0;
      q = d / (2 * cs);
      r = d % (2 * cs);
      if (r > cs) q++;
      if (q > count - 1) q = count - 1;
      return q;
    endfunction

    function longint cell_center(longint org, longint idx);
      longint c;
      c = org + eff_cell() / 2 + eff_cell() * idx;
      if (c > 64'sd2147483647) c = 64'sd2147483647;
      if (c < -64'sd2147483648) c = -64'sd2147483648;
      return c;
    endfunction

    // Squares wrap at 64 bits; only the final sum saturates.
    function longint unsigned goal_dist(longint ax, longint ay, longint bx, longint by);
      longint dx, dy;
      longint unsigned ux, uy, sx, sy, s;
      dx = ax - bx;
      dy = ay - by;
      ux = (dx < 0) ? -dx : dx;
      uy = (dy < 0) ? -dy : dy;
      sx = ux * ux;
      sy = uy * uy;
      s = sx + sy;
      if (s < sx) s = '1;
      return s;
    endfunction

    function void note_request(logic [1:0] cmd, logic [31:0] px, logic [31:0] py,
                               logic [31:0] gx, logic [31:0] gy);
      cell_result_t res;
      longint cols, rows, xc, yc, rad, c, r, cx, cy, ai, aj;
      longint unsigned d, best;
      bit have;
      cols = eff_count(ucols, GRID_COLS_DEF);
      rows = eff_count(urows, GRID_ROWS_DEF);
      xc = cell_index($signed(px), org_x, cols);
      yc = cell_index($signed(py), org_y, rows);
      res = '0;
      if (cmd == CMD_VISIT || cmd == CMD_UNREACH) begin
        marks[yc * GRID_COLS_DEF + xc] = (cmd == CMD_VISIT) ? MARK_VISITED : MARK_UNREACH;
        cx = cell_center(org_x, xc);
        cy = cell_center(org_y, yc);
        res.col = xc[5:0];
        res.row = yc[5:0];
        res.x = cx[31:0];
        res.y = cy[31:0];
      end else if (cmd == CMD_PLAN) begin
        rad = (outer > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : outer;
        have = 0;
        best = 0;
        for (longint di = -rad; di <= rad; di++) begin
          for (longint dj = -rad; dj <= rad; dj++) begin
            c = xc + di;
            r = yc + dj;
            ai = (di < 0) ? -di : di;
            aj = (dj < 0) ? -dj : dj;
            if (ai < inner && aj < inner) continue;
            if (c < 0 || c >= cols || r < 0 || r >= rows) continue;
            if (marks[r * GRID_COLS_DEF + c] != MARK_FREE) continue;
            cx = cell_center(org_x, c);
            cy = cell_center(org_y, r);
            d = goal_dist(cx, cy, $signed(gx), $signed(gy));
            if (!have || d < best) begin
              have = 1;
              best = d;
              res.found = 1'b1;
              res.col = c[5:0];
              res.row = r[5:0];
              res.x = cx[31:0];
              res.y = cy[31:0];
            end
          end
        end
      end
      awaited_q = {awaited_q, res};
    endfunction

    function void check_result(cell_result_t got);
      cell_result_t exp;
      if (awaited_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
        return;
      end
      exp = awaited_q.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected found=%0d col=%0d row=%0d x=%h y=%h",
                   exp.found, exp.col, exp.row, exp.x, exp.y);
          $display("          got      found=%0d col=%0d row=%0d x=%h y=%h",
                   got.found, got.col, got.row, got.x, got.y);
        end
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall;
  logic [1:0] command;
  logic signed [31:0] pos_x, pos_y, goal_x, goal_y;
  logic out_valid, out_stall;
  logic found;
  logic [5:0] target_col, target_row;
  logic signed [31:0] target_x, target_y;

  goal_cell_board board;
  // With calm set, neither side inserts gaps or stalls.
  bit calm;
  int stall_left;
  int stall_draw;
  longint cycles;

  grid_ring_goal_cell_select_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .pos_x(pos_x), .pos_y(pos_y), .goal_x(goal_x), .goal_y(goal_y),
    .out_valid(out_valid), .out_stall(out_stall), .found(found),
    .target_col(target_col), .target_row(target_row),
    .target_x(target_x), .target_y(target_y)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: after every accepted result, stall may be held high for a random while; never when calm.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      board.check_result({found, target_col, target_row, target_x, target_y});
      stall_draw = calm ? 0 : $urandom_range(0, 9);
      stall_left <= stall_draw;
      out_stall <= (stall_draw != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // A register write happens only while no request is in flight.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.write_reg(idx, v);
  endtask

  // Sends one request. Valid stays high into the next request when no gap is drawn.
  task automatic send_request(logic [1:0] cmd, logic [31:0] px, logic [31:0] py,
                              logic [31:0] gx, logic [31:0] gy);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    pos_x <= px;
    pos_y <= py;
    goal_x <= gx;
    goal_y <= gy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(cmd, px, py, gx, gy);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.awaited_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // A coordinate near the used grid: cell boundaries (ties) come up often, and some values
  // are drawn from the whole 32-bit range so every bit of the field toggles.
  function automatic logic [31:0] near_coord(longint org, longint n);
    longint cs, v, k;
    cs = board.eff_cell();
    if ($urandom_range(0, 9) == 0) return $urandom();
    k = $urandom_range(0, 32'(n + 3));
    v = org + cs * (k - 2);
    case ($urandom_range(0, 3))
      0: ;
      1: v = v + cs / 2;
      default: v = v + ({$urandom(), $urandom()} % cs);
    endcase
    return v[31:0];
  endfunction

  task automatic set_phase_config(int ph);
    logic [31:0] ox, oy, cs, nc, nr, ri, ro;
    case (ph)
      0: begin
        ox = 32'h8000_0000; oy = 32'h8000_0000; cs = 32'd1;
        nc = 32'd64; nr = 32'd64; ri = 32'd0; ro = 32'd8;
      end
      1: begin
        ox = 32'h7fff_ffff; oy = 32'h7fff_ffff; cs = 32'h7fff_ffff;
        nc = 32'd0; nr = 32'd127; ri = 32'd8; ro = 32'd15;
      end
      2: begin
        ox = $urandom(); oy = $urandom(); cs = 32'h8000_0000;
        nc = 32'd1; nr = 32'd1; ri = 32'd15; ro = 32'd0;
      end
      default: begin
        ox = ($urandom_range(0, 1) == 1) ? $urandom() : $urandom_range(0, 1 << 20) - (1 << 19);
        oy = ($urandom_range(0, 1) == 1) ? $urandom() : $urandom_range(0, 1 << 20) - (1 << 19);
        case ($urandom_range(0, 3))
          0: cs = 32'd65536;
          1: cs = $urandom_range(1, 64);
          2: cs = $urandom();
          default: cs = $urandom_range(1, 1 << 20);
        endcase
        nc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
        nr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
        ri = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
        ro = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
        nc[31:7] = 25'($urandom());
        nr[31:7] = 25'($urandom());
        ri[31:4] = 28'($urandom());
        ro[31:4] = 28'($urandom());
      end
    endcase
    write_cfg(CFG_ORIGIN_X, ox);
    write_cfg(CFG_ORIGIN_Y, oy);
    write_cfg(CFG_CELL, cs);
    write_cfg(CFG_COLS, nc);
    write_cfg(CFG_ROWS, nr);
    write_cfg(CFG_INNER, ri);
    write_cfg(CFG_OUTER, ro);
    if (ph == 3) write_cfg(CFG_NONE, $urandom());
  endtask

  initial begin
    longint n_cols, n_rows;
    logic [1:0] cmd;
    int pick;
    board = new();
    rst = 1'b1;
    cycles = 0;
    calm = 0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_PLAN;
    pos_x = '0;
    pos_y = '0;
    goal_x = '0;
    goal_y = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset settings: a plan on an empty grid, extremes of every
    // field, a goal exactly between cells, marks that block the ring, and command 3.
    send_request(CMD_PLAN, 32'h0002_8000, 32'h0002_8000, 32'h0002_8000, 32'h0000_0000);
    send_request(CMD_PLAN, 32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_request(CMD_PLAN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_request(CMD_PLAN, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff);
    send_request(CMD_PLAN, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    send_request(CMD_VISIT, 32'h0001_8000, 32'h0001_8000, 32'h0, 32'h0);
    send_request(CMD_UNREACH, 32'h0002_0000, 32'h0003_0000, 32'h0, 32'h0);
    send_request(CMD_VISIT, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);
    // Surround cell (0,0) so a plan from there finds an empty ring.
    send_request(CMD_VISIT, 32'h0000_8000, 32'h0001_8000, 32'h0, 32'h0);
    send_request(CMD_UNREACH, 32'h0001_8000, 32'h0000_8000, 32'h0, 32'h0);
    send_request(CMD_VISIT, 32'h0002_8000, 32'h0000_8000, 32'h0, 32'h0);
    send_request(CMD_VISIT, 32'h0002_8000, 32'h0001_8000, 32'h0, 32'h0);
    send_request(CMD_VISIT, 32'h0000_8000, 32'h0002_8000, 32'h0, 32'h0);
    send_request(CMD_VISIT, 32'h0001_8000, 32'h0002_8000, 32'h0, 32'h0);
    send_request(CMD_VISIT, 32'h0002_8000, 32'h0002_8000, 32'h0, 32'h0);
    send_request(CMD_PLAN, 32'h0000_8000, 32'h0000_8000, 32'h0010_0000, 32'h0010_0000);
    send_request(CMD_PLAN, 32'h0001_8000, 32'h0001_8000, 32'h0000_0000, 32'h0000_0000);
    send_request(CMD_UNKNOWN, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_request(CMD_UNKNOWN, 32'h0, 32'h0, 32'h0, 32'h0);
    send_request(CMD_PLAN, 32'h0020_0000, 32'h0020_0000, 32'hffff_0000, 32'h0040_0000);
    drain();

    // Random phases, each with fresh register values; every fourth phase runs without gaps.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_phase_config(ph);
      calm = (ph % 4 == 3);
      n_cols = board.eff_count(board.ucols, GRID_COLS_DEF);
      n_rows = board.eff_count(board.urows, GRID_ROWS_DEF);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 11) cmd = CMD_PLAN;
        else if (pick < 15) cmd = CMD_VISIT;
        else if (pick < 19) cmd = CMD_UNREACH;
        else cmd = CMD_UNKNOWN;
        send_request(cmd, near_coord(board.org_x, n_cols), near_coord(board.org_y, n_rows),
                     near_coord(board.org_x, n_cols), near_coord(board.org_y, n_rows));
      end
      drain();
    end
    calm = 0;

    if (board.errors == 0 && board.awaited_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/grgcs_pkg.sv
rtl/grgcs_quant.sv
rtl/grgcs_ctrl.sv
rtl/grgcs_dp.sv
rtl/grid_ring_goal_cell_select_top.sv
verif/grid_ring_goal_cell_select_top_test.sv
